// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SWCN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SWCN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swcn_pkg.sv =====
// Types, constants and codes shared by the calibration normalizer files.
package swcn_pkg;

  localparam int SENSORS_DEFAULT = 64;

  localparam int MODE_W    = 3;
  localparam int INDEX_W   = 6;
  localparam int READING_W = 20;
  localparam int RESULT_W  = 32;
  localparam int STORE_W   = 21;
  localparam int FACTOR_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // shared divider: dividend holds a 21-bit magnitude shifted up by 16
  localparam int DIV_DW = STORE_W + 16;
  localparam int DIV_VW = STORE_W;

  localparam logic [STORE_W-1:0] CLEAR_LOW_PEAK = 21'd844800;  // 3300 mV in Q13.8

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEAK     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HIGH_ADD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOW_ADD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NORM     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FACTOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD       = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   sensor_index;
    logic [READING_W-1:0] reading_q8;
  } item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] normalized_value;
    logic                       range_error;
  } result_t;

endpackage

// ===== hdl/swcn_div.sv =====
// Restoring divider, one quotient bit per cycle.
module swcn_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [swcn_pkg::DIV_DW-1:0]     dividend,
  input  logic [swcn_pkg::DIV_VW-1:0]     divisor,
  output logic                            done,
  output logic [swcn_pkg::DIV_DW-1:0]     quotient
);

  localparam int DW = swcn_pkg::DIV_DW;
  localparam int VW = swcn_pkg::DIV_VW;
  localparam int CW = $clog2(DW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW-1:0] den;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so VW bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (run) begin
      quotient <= {quotient[DW-2:0], fits};
      rem      <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

// ===== hdl/sensor_window_calibration_normalizer_unit.sv =====
// Per-sensor calibration window store with peak/mean update and normalization.
// Each item passes ST_RD and ST_LOAD; clear, unused modes and out-of-range indexes then
// go to ST_FIN, a peak sample through ST_PREP and ST_PEAKL, mean adds and normalize
// through ST_PREP, the 37-step shared divider (ST_DIV) and ST_POST (normalize skips the
// divider on an empty window). One item in flight; item_ready rises with result_valid.
// After rst the store is swept to zero with item_ready low; config writable throughout.
module sensor_window_calibration_normalizer_unit #(
  parameter int SENSORS = swcn_pkg::SENSORS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  swcn_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output swcn_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swcn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swcn_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW = swcn_pkg::STORE_W;
  localparam int RW = swcn_pkg::READING_W;
  localparam int FW = swcn_pkg::FACTOR_W;
  localparam int DW = swcn_pkg::DIV_DW;
  localparam int AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int EW = (AW > swcn_pkg::INDEX_W) ? AW : swcn_pkg::INDEX_W;
  localparam int PW = RW + FW + 1;

  typedef struct packed {
    logic [SW-1:0] hi;
    logic [SW-1:0] lo;
  } window_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_LOAD, ST_PREP, ST_PEAKL, ST_DIV, ST_POST, ST_FIN
  } state_t;

  state_t state;

  // configuration
  logic [FW-1:0] max_factor;
  logic [FW-1:0] min_factor;
  logic [FW-1:0] sample_count;
  logic          method;

  // item and working registers
  logic [swcn_pkg::MODE_W-1:0]  mode_q;
  logic [swcn_pkg::INDEX_W-1:0] idx_q;
  logic [RW-1:0]                reading_q;
  logic [SW-1:0]                hi_w;
  logic [SW-1:0]                lo_w;
  logic [PW-1:0]                prod;
  logic                         neg_q;
  logic [swcn_pkg::RESULT_W-1:0] norm_w;
  logic [AW-1:0]                clr_addr;

  // store
  window_t mem [SENSORS];
  window_t rd_data;
  logic    mem_we;
  logic [AW-1:0] mem_wa;
  window_t mem_wd;

  logic [EW-1:0] idx_ext;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          fin_go;
  logic          err;
  logic [SW:0]   r_ext;

  logic          use_lo_fac;
  logic [FW:0]   fac;
  logic [FW-1:0] n_eff;
  logic          r_below_lo;
  logic [SW-1:0] mag;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [swcn_pkg::DIV_VW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [SW:0]   sum;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);

  assign idx_ext  = EW'(idx_q);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = (32'(idx_q) < 32'(SENSORS));
  assign fin_go   = !result_valid || result_ready;
  assign err      = !in_range || (hi_w <= lo_w);
  assign r_ext    = {1'b0, reading_q};

  // multiplier factor: 1 + f_hi or 1 - f_lo in Q1.16
  assign use_lo_fac = (state == ST_PREP) || (mode_q == swcn_pkg::MODE_LOW_ADD);
  assign fac = use_lo_fac ? ((FW+1)'(1) << FW) - {1'b0, min_factor}
                          : ((FW+1)'(1) << FW) + {1'b0, max_factor};
  assign n_eff = (sample_count == '0) ? FW'(1) : sample_count;

  assign r_below_lo = r_ext < {1'b0, lo_w};
  assign mag = r_below_lo ? (lo_w - r_ext[SW-1:0]) : (r_ext[SW-1:0] - lo_w);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(prod[PW-1:16]);
    div_divisor  = SW'(n_eff);
    if (state == ST_PREP) begin
      case (mode_q)
        swcn_pkg::MODE_HIGH_ADD, swcn_pkg::MODE_LOW_ADD: div_start = 1'b1;
        swcn_pkg::MODE_NORM: begin
          div_start    = (hi_w > lo_w);
          div_dividend = {mag, 16'b0};
          div_divisor  = hi_w - lo_w;
        end
        default: div_start = 1'b0;
      endcase
    end
  end

  assign sum = (mode_q == swcn_pkg::MODE_HIGH_ADD) ? ({1'b0, hi_w} + {1'b0, div_q[SW-1:0]})
                                                    : ({1'b0, lo_w} + {1'b0, div_q[SW-1:0]});

  swcn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // store write port: reset sweep, or write-back when the result leaves
  always_comb begin
    if (state == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_we = (state == ST_FIN) && fin_go && in_range;
      mem_wa = addr;
      mem_wd = '{hi: hi_w, lo: lo_w};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_factor   <= '0;
      min_factor   <= '0;
      sample_count <= FW'(1);
      method       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swcn_pkg::REG_MAX_FACTOR:   max_factor   <= cfg_data;
        swcn_pkg::REG_MIN_FACTOR:   min_factor   <= cfg_data;
        swcn_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data;
        swcn_pkg::REG_METHOD:       method       <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      // in ST_FIN the result register is reloaded instead
      if (result_valid && result_ready && state != ST_FIN) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(SENSORS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            mode_q    <= item.mode;
            idx_q     <= item.sensor_index;
            reading_q <= item.reading_q8;
            state     <= ST_RD;
          end
        end
        ST_RD: state <= ST_LOAD;
        ST_LOAD: begin
          prod <= PW'(reading_q) * PW'(fac);
          if (mode_q == swcn_pkg::MODE_CLEAR) begin
            hi_w <= '0;
            lo_w <= method ? '0 : swcn_pkg::CLEAR_LOW_PEAK;
          end else begin
            hi_w <= rd_data.hi;
            lo_w <= rd_data.lo;
          end
          if (in_range && mode_q >= swcn_pkg::MODE_PEAK && mode_q <= swcn_pkg::MODE_NORM) begin
            state <= ST_PREP;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_PREP: begin
          neg_q <= r_below_lo;
          case (mode_q)
            swcn_pkg::MODE_PEAK: begin
              // product of 1 + f_hi stays below 2^37, so the upper bits fit the store
              if (r_ext > {1'b0, hi_w}) begin
                hi_w <= prod[PW-1:16];
              end
              prod  <= PW'(reading_q) * PW'(fac);
              state <= ST_PEAKL;
            end
            swcn_pkg::MODE_NORM: state <= (hi_w > lo_w) ? ST_DIV : ST_FIN;
            default:             state <= ST_DIV;
          endcase
        end
        ST_PEAKL: begin
          if (r_below_lo) begin
            lo_w <= prod[PW-1:16];
          end
          state <= ST_FIN;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          case (mode_q)
            swcn_pkg::MODE_HIGH_ADD: hi_w <= sum[SW] ? '1 : sum[SW-1:0];
            swcn_pkg::MODE_LOW_ADD:  lo_w <= sum[SW] ? '1 : sum[SW-1:0];
            default: begin
              if (neg_q) begin
                norm_w <= (div_q > DW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                              : 32'(-div_q[31:0]);
              end else begin
                norm_w <= (div_q > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
              end
            end
          endcase
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            result_valid            <= 1'b1;
            result.range_error      <= err;
            result.normalized_value <= (mode_q == swcn_pkg::MODE_NORM && !err) ? norm_w : '0;
            state                   <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/swcn_checker.sv =====
// Port-level checker for the calibration normalizer, bound to the top level.
`include "assert_macros.svh"

module swcn_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input swcn_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input swcn_pkg::result_t result
);

  // a stalled result transaction holds its payload
  `SWCN_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

  // flagged window never carries a normalized value
  `SWCN_ASSERT_IMP(a_err_zero, result_valid && result.range_error, result.normalized_value == 0, "nonzero value with range error")

  // one item at a time: busy right after an accepted transaction
  `SWCN_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "ready right after accept")

  // no result can appear the cycle after an item was taken
  `SWCN_ASSERT_NXT(a_no_instant_result, item_valid && item_ready, !$rose(result_valid), "result too early")

endmodule

bind sensor_window_calibration_normalizer_unit swcn_checker u_swcn_checker (.*);

// ===== tb/sv/sensor_window_calibration_normalizer_unit_tb.sv =====
// Self-checking testbench for the sensor calibration window normalizer.
module sensor_window_calibration_normalizer_unit_tb;
  import swcn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 95;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [63:0] STORE_MAX = (64'd1 << STORE_W) - 64'd1;
  localparam logic [READING_W-1:0] READ_MAX = '1;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } vector_t;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block's window store and registers
  logic [STORE_W-1:0] shadow_high [SENSORS_DEFAULT];
  logic [STORE_W-1:0] shadow_low [SENSORS_DEFAULT];
  logic [FACTOR_W-1:0] hi_factor;
  logic [FACTOR_W-1:0] lo_factor;
  logic [CFG_DATA_W-1:0] avg_rounds;
  logic mean_method;

  result_t pending_results [$];
  vector_t vectors [$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  int ready_hold = 0;

  sensor_window_calibration_normalizer_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [STORE_W-1:0] clip_store(input logic [63:0] v);
    return (v > STORE_MAX) ? STORE_MAX[STORE_W-1:0] : v[STORE_W-1:0];
  endfunction

  // applies one item to the shadow window and returns the result it yields
  function automatic result_t predict_window(input item_t it);
    logic [63:0] r, hi, lo, rounds, mag, q;
    logic neg;
    result_t res;
    r = 64'(it.reading_q8);
    hi = 64'(shadow_high[it.sensor_index]);
    lo = 64'(shadow_low[it.sensor_index]);
    rounds = (avg_rounds == 0) ? 64'd1 : 64'(avg_rounds);
    res = '0;
    case (it.mode)
      MODE_CLEAR: begin
        hi = 64'd0;
        lo = mean_method ? 64'd0 : 64'(CLEAR_LOW_PEAK);
      end
      MODE_PEAK: begin
        if (r > hi) hi = 64'(clip_store((r * (64'd65536 + 64'(hi_factor))) >> 16));
        if (r < lo) lo = 64'(clip_store((r * (64'd65536 - 64'(lo_factor))) >> 16));
      end
      MODE_HIGH_ADD: begin
        hi = 64'(clip_store(hi + (r * (64'd65536 + 64'(hi_factor))) / (rounds << 16)));
      end
      MODE_LOW_ADD: begin
        lo = 64'(clip_store(lo + (r * (64'd65536 - 64'(lo_factor))) / (rounds << 16)));
      end
      default: ;
    endcase
    shadow_high[it.sensor_index] = hi[STORE_W-1:0];
    shadow_low[it.sensor_index] = lo[STORE_W-1:0];
    res.range_error = (hi <= lo);
    if (it.mode == MODE_NORM && !res.range_error) begin
      neg = (r < lo);
      mag = neg ? lo - r : r - lo;
      q = (mag << 16) / (hi - lo);
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        q = 64'd0 - q;
      end else if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF;
      end
      res.normalized_value = q[31:0];
    end
    return res;
  endfunction

  function automatic void add_row(input logic [MODE_W-1:0] mode, input int idx,
                                  input logic [READING_W-1:0] rd, input bit typed,
                                  input logic [31:0] want_value, input logic want_err);
    vector_t v;
    v.stim.mode = mode;
    v.stim.sensor_index = idx[INDEX_W-1:0];
    v.stim.reading_q8 = rd;
    v.typed = typed;
    v.want.normalized_value = want_value;
    v.want.range_error = want_err;
    vectors.push_back(v);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) it.mode = MODE_CLEAR;
    else if (pick < 30) it.mode = MODE_PEAK;
    else if (pick < 45) it.mode = MODE_HIGH_ADD;
    else if (pick < 57) it.mode = MODE_LOW_ADD;
    else if (pick < 95) it.mode = MODE_NORM;
    else it.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    // most traffic on a few sensors so windows actually build up
    if ($urandom_range(0, 9) < 8) it.sensor_index = INDEX_W'($urandom_range(0, 7));
    else it.sensor_index = INDEX_W'($urandom_range(0, SENSORS_DEFAULT - 1));
    case ($urandom_range(0, 9))
      0: it.reading_q8 = '0;
      1: it.reading_q8 = READ_MAX;
      2, 3: it.reading_q8 = READING_W'($urandom_range(0, 4095));
      default: it.reading_q8 = READING_W'($urandom);
    endcase
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t model_res;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    model_res = predict_window(it);
    pending_results.push_back(typed ? typed_res : model_res);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_FACTOR:   hi_factor = val;
      REG_MIN_FACTOR:   lo_factor = val;
      REG_SAMPLE_COUNT: avg_rounds = val;
      REG_METHOD:       mean_method = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] mf, input logic [15:0] nf,
                                input logic [15:0] sc, input logic meth);
    write_reg(REG_MAX_FACTOR, mf);
    write_reg(REG_MIN_FACTOR, nf);
    write_reg(REG_SAMPLE_COUNT, sc);
    write_reg(REG_METHOD, CFG_DATA_W'(meth));
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      result_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      result_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing pending: value %0d flag %0b", $time,
                 result.normalized_value, result.range_error);
      end else begin
        want = pending_results.pop_front();
        if (result.normalized_value !== want.normalized_value) begin
          mismatch_count++;
          $display("%0t: normalized_value expected %0d got %0d", $time,
                   want.normalized_value, result.normalized_value);
        end
        if (result.range_error !== want.range_error) begin
          mismatch_count++;
          $display("%0t: range_error expected %0b got %0b", $time,
                   want.range_error, result.range_error);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    result_t none;
    item_t it;
    logic [15:0] mf, nf, sc;
    logic meth;
    none = '0;
    foreach (shadow_high[s]) begin
      shadow_high[s] = '0;
      shadow_low[s] = '0;
    end
    hi_factor = '0;
    lo_factor = '0;
    avg_rounds = 16'd1;
    mean_method = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    apply_settings(16'h0000, 16'h0000, 16'h0001, 1'b0);

    // reset window, clear values, peak and mean updates, unused modes, store and output saturation
    add_row(MODE_NORM, 0, '0, 1, 32'h0, 1'b1);
    add_row(MODE_NORM, 63, READ_MAX, 1, 32'h0, 1'b1);
    add_row(MODE_CLEAR, 5, 20'd777, 1, 32'h0, 1'b1);
    add_row(MODE_PEAK, 5, 20'd256000, 1, 32'h0, 1'b1);
    add_row(MODE_PEAK, 5, 20'd512000, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 5, 20'd384000, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 5, '0, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 5, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_SPARE_LO, 5, 20'd12345, 0, 32'h0, 1'b0);
    add_row(MODE_SPARE_LO + 3'd1, 0, 20'hAAAAA, 1, 32'h0, 1'b1);
    add_row(MODE_SPARE_HI, 5, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_PEAK, 6, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 6, '0, 0, 32'h0, 1'b0);
    add_row(MODE_HIGH_ADD, 8, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_HIGH_ADD, 8, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_HIGH_ADD, 8, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_LOW_ADD, 8, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 8, READ_MAX, 0, 32'h0, 1'b0);
    add_row(MODE_HIGH_ADD, 9, 20'd1, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 9, READ_MAX, 1, 32'h7FFF_FFFF, 1'b0);
    add_row(MODE_LOW_ADD, 10, READ_MAX, 1, 32'h0, 1'b1);
    add_row(MODE_HIGH_ADD, 10, READ_MAX, 1, 32'h0, 1'b1);
    add_row(MODE_HIGH_ADD, 10, 20'd1, 0, 32'h0, 1'b0);
    add_row(MODE_NORM, 10, '0, 1, 32'h8000_0000, 1'b0);
    add_row(MODE_CLEAR, 63, 20'h55555, 1, 32'h0, 1'b1);

    idle_pct = 20;
    foreach (vectors[k]) send_item(vectors[k].stim, vectors[k].typed, vectors[k].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin mf = 16'hFFFF; nf = 16'hFFFF; sc = 16'd1; meth = 1'b0; end
        1: begin mf = 16'h0000; nf = 16'h0000; sc = 16'd0; meth = 1'b1; end
        2: begin mf = 16'hFFFF; nf = 16'hFFFF; sc = 16'hFFFF; meth = 1'b1; end
        3: begin mf = 16'h8000; nf = 16'h4000; sc = 16'd3; meth = 1'b1; end
        4: begin mf = 16'h0000; nf = 16'hFFFF; sc = 16'd1; meth = 1'b0; end
        default: begin
          mf = 16'($urandom);
          nf = 16'($urandom);
          sc = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
          meth = 1'($urandom_range(0, 1));
        end
      endcase
      apply_settings(mf, nf, sc, meth);
      // no idling in the last phases, nor in phase 1
      if (p == 1 || p >= PHASES - 2) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 1) != 0) ? 15 : 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        send_item(it, 1'b0, none);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sensor_window_calibration_normalizer_unit.f =====
+incdir+hdl
hdl/swcn_pkg.sv
hdl/swcn_div.sv
hdl/sensor_window_calibration_normalizer_unit.sv
hdl/swcn_checker.sv
tb/sv/sensor_window_calibration_normalizer_unit_tb.sv
